@@ hw/rtl/wecc_pkg.sv @@
// Package: shared types and constants for the write/erase command coalescer.
package wecc_pkg;

    localparam int BUFFER_ENTRIES = 5;
    localparam int IDX_W = $clog2(BUFFER_ENTRIES);
    localparam int CNT_W = $clog2(BUFFER_ENTRIES + 1);
    localparam int ADDR_W = 7;
    localparam int LEN_W = 7;
    localparam int DATA_W = 32;
    localparam logic [LEN_W-1:0] MAX_ERASE_RESET = 7'd10;

    localparam logic [1:0] OPC_WRITE = 2'd0;
    localparam logic [1:0] OPC_ERASE = 2'd1;
    localparam logic [1:0] OPC_READ = 2'd2;
    localparam logic [1:0] OPC_FLUSH = 2'd3;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_ERASE = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    typedef struct packed {
        logic             valid;
        logic             is_erase;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  len;
    } t_entry;

    // Controller to datapath commands
    typedef struct packed {
        logic             load;      // latch incoming command
        logic             place;     // store new entry at count
        logic             merge;     // merge new entry against entry at idx
        logic             compact;   // one compaction step at idx
        logic             clear;     // empty the buffer (with place, keep only the new entry)
        logic             read_step; // read scan step at idx
        logic             out_load;  // put a result in the output register
        logic             out_is_read;
        logic             out_last;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             entry_valid;  // entry at idx valid
        logic [1:0]       cmd;
        logic             zero_len;
    } t_dp_sts;

endpackage

@@ hw/rtl/wecc_datapath.sv @@
// Datapath: entry store, merge unit, compaction, read scan and output register.
module wecc_datapath import wecc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_data,
    input  logic [1:0]        i_command,
    input  logic [ADDR_W-1:0] i_block_address,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [LEN_W-1:0]  i_erase_length,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    output logic [1:0]        o_result_kind,
    output logic [ADDR_W-1:0] o_result_address,
    output logic [DATA_W-1:0] o_result_data,
    output logic [LEN_W-1:0]  o_result_length,
    output logic              o_buffer_hit,
    output logic              o_last_result
);

    t_entry            r_store [BUFFER_ENTRIES];
    logic [CNT_W-1:0]  r_count;
    logic [LEN_W-1:0]  r_max_len;
    logic [1:0]        r_cmd;
    t_entry            r_cur;     // incoming entry, widened by merges
    logic [CNT_W-1:0]  r_wr;      // compaction write pointer
    logic              r_hit;
    logic [DATA_W-1:0] r_rdata;

    t_entry            w_prev;
    t_entry            n_prev;
    t_entry            n_cur;
    logic [8:0]        w_b, w_e, w_nb, w_ne, w_cs, w_ce, w_ps, w_pe, w_lo, w_hi, w_cnt;
    logic              w_rd_match;
    logic              w_rd_take;

    assign w_prev = r_store[i_cmd.idx];

    always_comb begin
        n_prev = w_prev;
        n_cur  = r_cur;
        w_b  = {2'b0, w_prev.addr};
        w_e  = w_b + {2'b0, w_prev.len} - 9'd1;
        w_nb = w_b + ((r_cur.addr == w_prev.addr) ? 9'd1 : 9'd0);
        w_ne = w_e - (({2'b0, r_cur.addr} == w_e) ? 9'd1 : 9'd0);
        w_cs = {2'b0, r_cur.addr};
        w_ce = w_cs + {2'b0, r_cur.len} - 9'd1;
        w_ps = w_b;
        w_pe = w_e;
        w_lo = (w_ps < w_cs) ? w_ps : w_cs;
        w_hi = (w_pe > w_ce) ? w_pe : w_ce;
        w_cnt = w_hi - w_lo + 9'd1;
        if (w_prev.valid) begin
            if (!r_cur.is_erase) begin
                if (!w_prev.is_erase) begin
                    if (w_prev.addr == r_cur.addr) n_prev.valid = 1'b0;
                end else if (w_nb <= w_ne) begin
                    n_prev.addr = w_nb[ADDR_W-1:0];
                    n_prev.len  = LEN_W'(w_ne - w_nb + 9'd1);
                end else begin
                    n_prev.valid = 1'b0;
                end
            end else if (!w_prev.is_erase) begin
                if (w_ps >= w_cs && w_ps <= w_ce) n_prev.valid = 1'b0;
            end else if (!(w_ps > w_ce + 9'd1 || w_pe + 9'd1 < w_cs)) begin
                if (w_cnt <= {2'b0, r_max_len}) begin
                    n_cur.addr   = w_lo[ADDR_W-1:0];
                    n_cur.len    = w_cnt[LEN_W-1:0];
                    n_prev.valid = 1'b0;
                end
            end
        end
    end

    always_comb begin
        w_rd_match = 1'b0;
        if (w_prev.valid) begin
            if (!w_prev.is_erase) w_rd_match = (w_prev.addr == r_cur.addr);
            else w_rd_match = ({2'b0, r_cur.addr} >= w_b) &&
                              ({2'b0, r_cur.addr} < w_b + {2'b0, w_prev.len});
        end
    end

    // match on the current scan step, seen by the output register on the last step
    assign w_rd_take = i_cmd.read_step && w_rd_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_max_len <= MAX_ERASE_RESET;
            r_wr      <= '0;
            for (int k = 0; k < BUFFER_ENTRIES; k++) r_store[k].valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_max_len <= i_cfg_data;
            if (i_cmd.load) begin
                r_cmd          <= i_command;
                r_cur.valid    <= 1'b1;
                r_cur.is_erase <= (i_command == OPC_ERASE);
                r_cur.addr     <= i_block_address;
                r_cur.data     <= (i_command == OPC_ERASE) ? '0 : i_write_data;
                r_cur.len      <= (i_command == OPC_ERASE) ? i_erase_length : '0;
                r_hit          <= 1'b0;
                r_rdata        <= '0;
                r_wr           <= '0;
            end
            if (i_cmd.clear) begin
                // clear with place: the spilling command becomes the only entry
                r_count <= i_cmd.place ? CNT_W'(1) : CNT_W'(0);
                for (int k = 0; k < BUFFER_ENTRIES; k++) begin
                    if (i_cmd.place && k == 0) r_store[k] <= r_cur;
                    else r_store[k].valid <= 1'b0;
                end
            end else if (i_cmd.place) begin
                r_store[r_count[IDX_W-1:0]] <= r_cur;
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.merge) begin
                r_store[i_cmd.idx] <= n_prev;
                r_store[r_count[IDX_W-1:0] - IDX_W'(1)] <= n_cur;
                r_cur <= n_cur;
            end
            if (i_cmd.compact) begin
                if (w_prev.valid) begin
                    r_store[r_wr[IDX_W-1:0]] <= w_prev;
                    if (r_wr[IDX_W-1:0] != i_cmd.idx) r_store[i_cmd.idx].valid <= 1'b0;
                    r_wr <= r_wr + CNT_W'(1);
                end
                if (i_cmd.idx == IDX_W'(BUFFER_ENTRIES - 1))
                    r_count <= r_wr + CNT_W'(w_prev.valid);
            end
            if (w_rd_take) begin
                r_hit   <= 1'b1;
                r_rdata <= w_prev.is_erase ? '0 : w_prev.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_last_result <= i_cmd.out_last;
            if (i_cmd.out_is_read) begin
                o_result_kind    <= KIND_READ;
                o_result_address <= r_cur.addr;
                o_result_data    <= w_rd_take ? (w_prev.is_erase ? '0 : w_prev.data)
                                              : r_rdata;
                o_result_length  <= '0;
                o_buffer_hit     <= r_hit || w_rd_take;
            end else begin
                o_result_kind    <= w_prev.is_erase ? KIND_ERASE : KIND_WRITE;
                o_result_address <= w_prev.addr;
                o_result_data    <= w_prev.is_erase ? '0 : w_prev.data;
                o_result_length  <= w_prev.is_erase ? w_prev.len : '0;
                o_buffer_hit     <= 1'b0;
            end
        end
    end

    assign o_sts.count       = r_count;
    assign o_sts.entry_valid = w_prev.valid;
    assign o_sts.cmd         = r_cmd;
    assign o_sts.zero_len    = (r_cur.len == '0);

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(BUFFER_ENTRIES)) else $error("count overflow");
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear && !i_cmd.place |=> r_count == '0) else $error("clear failed");
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({i_cmd.merge, i_cmd.place || i_cmd.clear, i_cmd.compact}) <= 1)
        else $error("conflicting datapath commands");
`endif

endmodule

@@ hw/rtl/wecc_controller.sv @@
// Controller: sequences merge, compaction, read scan and result emission.
module wecc_controller import wecc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_in_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_EMIT, S_MERGE, S_COMPACT, S_READ
    } t_state;

    t_state            r_state;
    logic [IDX_W-1:0]  r_idx;
    logic              r_out_valid;
    logic              r_after_emit; // emission was a full-buffer spill

    assign o_in_ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_valid    = r_out_valid;

    always_comb begin
        o_cmd      = '0;
        o_cmd.idx  = r_idx;
        o_cmd.load = o_in_ready && i_valid;
        case (r_state)
            S_EMIT: begin
                if (!r_out_valid) begin
                    if (r_idx < i_sts.count[IDX_W-1:0] ||
                        i_sts.count == CNT_W'(BUFFER_ENTRIES)) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_last = (CNT_W'(r_idx) + CNT_W'(1) == i_sts.count);
                    end
                    if (CNT_W'(r_idx) + CNT_W'(1) >= i_sts.count) begin
                        o_cmd.clear = 1'b1;
                        o_cmd.place = r_after_emit;
                    end
                end
            end
            S_MERGE:   o_cmd.merge = 1'b1;
            S_COMPACT: o_cmd.compact = 1'b1;
            S_READ: begin
                o_cmd.read_step = (CNT_W'(r_idx) < i_sts.count);
                if (r_idx == IDX_W'(BUFFER_ENTRIES - 1)) begin
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_is_read = 1'b1;
                    o_cmd.out_last    = 1'b1;
                end
            end
            S_DECODE: begin
                if ((i_sts.cmd == OPC_WRITE || (i_sts.cmd == OPC_ERASE && !i_sts.zero_len))
                    && i_sts.count != CNT_W'(BUFFER_ENTRIES)) o_cmd.place = 1'b1;
                if (i_sts.cmd == OPC_FLUSH) o_cmd.clear = (i_sts.count == '0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
            r_after_emit <= 1'b0;
        end else begin
            if (o_cmd.out_load) r_out_valid <= 1'b1;
            else if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (o_cmd.load) r_state <= S_DECODE;
                S_DECODE: begin
                    r_idx <= '0;
                    case (i_sts.cmd)
                        OPC_READ: r_state <= S_READ;
                        OPC_FLUSH: begin
                            r_after_emit <= 1'b0;
                            r_state <= (i_sts.count == '0) ? S_IDLE : S_EMIT;
                        end
                        default: begin
                            if (i_sts.cmd == OPC_ERASE && i_sts.zero_len) r_state <= S_IDLE;
                            else if (i_sts.count == CNT_W'(BUFFER_ENTRIES)) begin
                                r_after_emit <= 1'b1;
                                r_state <= S_EMIT;
                            end else begin
                                r_after_emit <= 1'b0;
                                if (i_sts.count == '0) r_state <= S_IDLE;
                                else begin
                                    r_idx <= i_sts.count[IDX_W-1:0] - IDX_W'(1);
                                    r_state <= S_MERGE;
                                end
                            end
                        end
                    endcase
                end
                S_EMIT: begin
                    if (!r_out_valid) begin
                        if (o_cmd.clear) begin
                            r_state <= S_IDLE;
                            r_idx <= '0;
                        end else r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_MERGE: begin
                    if (r_idx == '0) r_state <= S_COMPACT;
                    else r_idx <= r_idx - IDX_W'(1);
                end
                S_COMPACT: begin
                    if (r_idx == IDX_W'(BUFFER_ENTRIES - 1)) begin
                        r_idx <= '0;
                        r_state <= S_IDLE;
                    end else r_idx <= r_idx + IDX_W'(1);
                end
                S_READ: begin
                    if (r_idx == IDX_W'(BUFFER_ENTRIES - 1)) begin
                        r_idx <= '0;
                        r_state <= S_IDLE;
                    end else r_idx <= r_idx + IDX_W'(1);
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE) else $error("accept while busy");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !r_out_valid) else $error("result overwritten");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_W'(BUFFER_ENTRIES - 1)) else $error("index out of range");
`endif

endmodule

@@ hw/rtl/write_erase_command_coalescer_unit.sv @@
// Top level: write/erase command coalescer, controller plus datapath.
//
//  channel | signals                         | direction
//  input   | i_valid / o_ready, command      | in
//  output  | o_valid / i_ready, result       | out
//  config  | i_cfg_we, i_cfg_data            | in
//
// A write or erase is accepted, placed in the decode state, then merged against each
// older entry in turn, one merge step per entry, and compacted in BUFFER_ENTRIES steps;
// into an empty buffer it is done once placed.
// A read scans all entries one per cycle; its result is registered at the last step,
// and input waits until the result is taken.
// A full buffer spills one entry per result transaction; output stalls hold it.
// Reset is synchronous, active low, and empties the buffer.
module write_erase_command_coalescer_unit import wecc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_command,
    input  logic [ADDR_W-1:0] i_block_address,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [LEN_W-1:0]  i_erase_length,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_result_kind,
    output logic [ADDR_W-1:0] o_result_address,
    output logic [DATA_W-1:0] o_result_data,
    output logic [LEN_W-1:0]  o_result_length,
    output logic              o_buffer_hit,
    output logic              o_last_result
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    wecc_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_in_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .i_sts(w_sts), .o_cmd(w_cmd)
    );

    wecc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_command(i_command), .i_block_address(i_block_address),
        .i_write_data(i_write_data), .i_erase_length(i_erase_length),
        .i_cmd(w_cmd), .o_sts(w_sts),
        .o_result_kind(o_result_kind), .o_result_address(o_result_address),
        .o_result_data(o_result_data), .o_result_length(o_result_length),
        .o_buffer_hit(o_buffer_hit), .o_last_result(o_last_result)
    );

endmodule
